// ===== rtl/text_cell_buffer_cursor_core_defines.svh =====
// Assertion macros shared by the text cell buffer RTL.
`ifndef TEXT_CELL_BUFFER_CURSOR_CORE_DEFINES_SVH
`define TEXT_CELL_BUFFER_CURSOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TCBC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TCBC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tcbc_pkg.sv =====
// Types and constants of the text cell buffer.
`timescale 1ns / 1ps

package tcbc_pkg;

   localparam int MAX_COLS_DEFAULT = 128;
   localparam int MAX_ROWS_DEFAULT = 64;

   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd25;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;

   localparam int         CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS    = 1'b1;

   typedef struct packed {
      logic       present;
      logic [7:0] code;
      logic [1:0] color;
   } cell_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_WRITE,
      ST_READ,
      ST_DEL,
      ST_FIN
   } state_type;

endpackage

// ===== rtl/text_cell_buffer_cursor_core.sv =====
// Character-cell text screen with a cursor, cells kept in one synchronous RAM.
//
// After reset the cell RAM is cleared one entry per cycle, all MAX_COLS *
// MAX_ROWS entries (8192 at the default size), and req_stall stays high until
// that pass ends; register writes are taken during the pass. One beat is
// worked on at a time: write and read step through accept, address multiply,
// RAM access and result, the unused mode skips the RAM access, and a delete
// puts one clearing step per cleared cell in its place, since the single RAM
// write port clears one cell per cycle. A finished result sits in an output
// register, so the next beat is accepted while the result still waits under
// rsp_stall; that next beat then holds in its result step until the waiting
// result has left.
`timescale 1ns / 1ps
`include "text_cell_buffer_cursor_core_defines.svh"

module text_cell_buffer_cursor_core #(
   parameter int MAX_COLS = tcbc_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = tcbc_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_mode,
   input  logic [7:0]                       req_char_code,
   input  logic [1:0]                       req_color,
   input  logic [7:0]                       req_delete_count,
   input  logic [6:0]                       req_read_col,
   input  logic [5:0]                       req_read_row,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [6:0]                       rsp_cursor_col,
   output logic [5:0]                       rsp_cursor_row,
   output logic                             rsp_cell_present,
   output logic [7:0]                       rsp_cell_char,
   output logic [1:0]                       rsp_cell_color,

   input  logic                             csr_wen,
   input  logic [tcbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);

   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNW   = $clog2(MAX_COLS + 1);
   localparam int RNW   = $clog2(MAX_ROWS + 1);
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PW    = RW + CNW + 1;

   function automatic logic [CNW-1:0] clamp_cols(input logic [7:0] v);
      logic [CNW-1:0] r;
      if (v == 8'd0) begin
         r = CNW'(1);
      end else if (int'(v) > MAX_COLS) begin
         r = CNW'(MAX_COLS);
      end else begin
         r = CNW'(v);
      end
      return r;
   endfunction

   function automatic logic [RNW-1:0] clamp_rows(input logic [6:0] v);
      logic [RNW-1:0] r;
      if (v == 7'd0) begin
         r = RNW'(1);
      end else if (int'(v) > MAX_ROWS) begin
         r = RNW'(MAX_ROWS);
      end else begin
         r = RNW'(v);
      end
      return r;
   endfunction

   tcbc_pkg::state_type state_ff, state_in;

   logic [7:0]     columns_ff, columns_in;
   logic [6:0]     rows_ff, rows_in;
   logic [CW-1:0]  cursor_x_ff, cursor_x_in;
   logic [RW-1:0]  cursor_y_ff, cursor_y_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic [AW-1:0]  lin_ff, lin_in;
   logic           rd_ok_ff, rd_ok_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [1:0]     mode_ff, mode_in;
   logic [7:0]     char_ff, char_in;
   logic [1:0]     color_ff, color_in;
   logic [7:0]     cnt_ff, cnt_in;
   logic [6:0]     rcol_ff, rcol_in;
   logic [5:0]     rrow_ff, rrow_in;

   logic [6:0]     rsp_col_ff;
   logic [5:0]     rsp_row_ff;
   logic           rsp_present_ff;
   logic [7:0]     rsp_char_ff;
   logic [1:0]     rsp_color_ff;

   logic [CNW-1:0] eff_cols, new_cols;
   logic [RNW-1:0] eff_rows, new_rows;
   logic [RW-1:0]  nl_y;
   logic [CW-1:0]  adj_x, xsel;
   logic [RW-1:0]  adj_y, ysel;
   logic [PW-1:0]  prod_sum;
   logic           del_go;
   logic           rsp_load;
   logic           show_cell;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   tcbc_pkg::cell_type mem_wdata;
   logic               mem_re;
   tcbc_pkg::cell_type mem_rdata;

   tcbc_ram #(
      .WIDTH ($bits(tcbc_pkg::cell_type)),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (lin_ff),
      .rd_data (mem_rdata)
   );

   assign eff_cols = clamp_cols(columns_ff);
   assign eff_rows = clamp_rows(rows_ff);

   // Row step used by a newline and by the wrap past the last column.
   assign nl_y = (int'(cursor_y_ff) + 1 < int'(eff_rows)) ? cursor_y_ff + 1'b1 : cursor_y_ff;

   always_comb begin
      if (mode_ff == tcbc_pkg::MODE_WRITE && char_ff == tcbc_pkg::NEWLINE_CODE) begin
         adj_x = '0;
         adj_y = nl_y;
      end else begin
         adj_x = cursor_x_ff;
         adj_y = cursor_y_ff;
      end
      if (mode_ff == tcbc_pkg::MODE_READ) begin
         xsel = CW'(rcol_ff);
         ysel = RW'(rrow_ff);
      end else begin
         xsel = adj_x;
         ysel = adj_y;
      end
      prod_sum = ysel * eff_cols + xsel;
   end

   assign del_go    = (cnt_ff != 8'd0) && (lin_ff != '0);
   assign show_cell = (mode_ff == tcbc_pkg::MODE_READ) && rd_ok_ff;

   always_comb begin
      state_in     = state_ff;
      columns_in   = columns_ff;
      rows_in      = rows_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      clr_addr_in  = clr_addr_ff;
      lin_in       = lin_ff;
      rd_ok_in     = rd_ok_ff;
      mode_in      = mode_ff;
      char_in      = char_ff;
      color_in     = color_ff;
      cnt_in       = cnt_ff;
      rcol_in      = rcol_ff;
      rrow_in      = rrow_ff;
      mem_we       = 1'b0;
      mem_waddr    = lin_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      rsp_load     = 1'b0;
      new_cols     = eff_cols;
      new_rows     = eff_rows;

      case (state_ff)
         tcbc_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            if (clr_addr_ff == AW'(CELLS - 1)) begin
               state_in = tcbc_pkg::ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         tcbc_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               char_in  = req_char_code;
               color_in = req_color;
               cnt_in   = req_delete_count;
               rcol_in  = req_read_col;
               rrow_in  = req_read_row;
               state_in = tcbc_pkg::ST_ADDR;
            end
         end
         tcbc_pkg::ST_ADDR: begin
            cursor_x_in = adj_x;
            cursor_y_in = adj_y;
            lin_in      = prod_sum[AW-1:0];
            rd_ok_in    = (int'(rcol_ff) < int'(eff_cols)) &&
                          (int'(rrow_ff) < int'(eff_rows));
            case (mode_ff)
               tcbc_pkg::MODE_WRITE:  state_in = tcbc_pkg::ST_WRITE;
               tcbc_pkg::MODE_DELETE: state_in = tcbc_pkg::ST_DEL;
               tcbc_pkg::MODE_READ:   state_in = tcbc_pkg::ST_READ;
               default:               state_in = tcbc_pkg::ST_FIN;
            endcase
         end
         tcbc_pkg::ST_WRITE: begin
            mem_we            = 1'b1;
            mem_wdata.present = 1'b1;
            mem_wdata.code    = char_ff;
            mem_wdata.color   = color_ff;
            if (int'(cursor_x_ff) + 1 >= int'(eff_cols)) begin
               cursor_x_in = '0;
               cursor_y_in = nl_y;
            end else begin
               cursor_x_in = cursor_x_ff + 1'b1;
            end
            state_in = tcbc_pkg::ST_FIN;
         end
         tcbc_pkg::ST_READ: begin
            mem_re   = rd_ok_ff;
            state_in = tcbc_pkg::ST_FIN;
         end
         tcbc_pkg::ST_DEL: begin
            // Clear one cell behind the cursor per cycle and step the cursor back
            // across the row boundary, so no division is needed for its position.
            if (del_go) begin
               mem_we    = 1'b1;
               mem_waddr = lin_ff - 1'b1;
               lin_in    = lin_ff - 1'b1;
               cnt_in    = cnt_ff - 1'b1;
               if (cursor_x_ff == '0) begin
                  cursor_x_in = CW'(eff_cols - 1'b1);
                  cursor_y_in = cursor_y_ff - 1'b1;
               end else begin
                  cursor_x_in = cursor_x_ff - 1'b1;
               end
            end else begin
               state_in = tcbc_pkg::ST_FIN;
            end
         end
         tcbc_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = tcbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcbc_pkg::ST_IDLE;
         end
      endcase

      // A register write pulls the cursor into the resized grid right away.
      if (csr_wen) begin
         case (csr_index)
            tcbc_pkg::CSR_COLUMNS: begin
               columns_in = csr_wdata;
               new_cols   = clamp_cols(csr_wdata);
            end
            tcbc_pkg::CSR_ROWS: begin
               rows_in  = csr_wdata[6:0];
               new_rows = clamp_rows(csr_wdata[6:0]);
            end
            default: begin
               columns_in = columns_ff;
            end
         endcase
         if (int'(cursor_x_in) >= int'(new_cols)) begin
            cursor_x_in = CW'(new_cols - 1'b1);
         end
         if (int'(cursor_y_in) >= int'(new_rows)) begin
            cursor_y_in = RW'(new_rows - 1'b1);
         end
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcbc_pkg::ST_CLEAR;
         columns_ff   <= tcbc_pkg::COLUMNS_RESET;
         rows_ff      <= tcbc_pkg::ROWS_RESET;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lin_ff   <= lin_in;
      rd_ok_ff <= rd_ok_in;
      mode_ff  <= mode_in;
      char_ff  <= char_in;
      color_ff <= color_in;
      cnt_ff   <= cnt_in;
      rcol_ff  <= rcol_in;
      rrow_ff  <= rrow_in;
      if (rsp_load) begin
         rsp_col_ff     <= 7'(cursor_x_ff);
         rsp_row_ff     <= 6'(cursor_y_ff);
         rsp_present_ff <= show_cell ? mem_rdata.present : 1'b0;
         rsp_char_ff    <= show_cell ? mem_rdata.code : 8'd0;
         rsp_color_ff   <= show_cell ? mem_rdata.color : 2'd0;
      end
   end

   assign req_stall        = (state_ff != tcbc_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_col   = rsp_col_ff;
   assign rsp_cursor_row   = rsp_row_ff;
   assign rsp_cell_present = rsp_present_ff;
   assign rsp_cell_char    = rsp_char_ff;
   assign rsp_cell_color   = rsp_color_ff;

   `TCBC_ASSERT_IMP(a_no_rsp_in_clear, state_ff == tcbc_pkg::ST_CLEAR, !rsp_valid_ff,
                    "result valid during clearing pass")
   `TCBC_ASSERT_IMP(a_cursor_in_grid, state_ff == tcbc_pkg::ST_IDLE,
                    (int'(cursor_x_ff) < int'(eff_cols)) && (int'(cursor_y_ff) < int'(eff_rows)),
                    "cursor outside grid while idle")
   `TCBC_ASSERT_NXT(a_accept_to_addr, state_ff == tcbc_pkg::ST_IDLE && req_valid,
                    state_ff == tcbc_pkg::ST_ADDR, "accepted beat did not start")
   `TCBC_ASSERT_NXT(a_delete_walks_back, state_ff == tcbc_pkg::ST_DEL && del_go,
                    lin_ff == $past(lin_ff) - 1'b1, "delete walk did not step back one cell")

endmodule

// ===== rtl/tcbc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module tcbc_ram #(
   parameter int WIDTH  = 11,
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
